// ===== rtl/bhpq_pkg.sv =====
// shared types and constants of the binary heap priority queue
package bhpq_pkg;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int TOP_W    = 32;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_PEEK
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_WAIT,
    S_UP_CMP,
    S_DN_RD,
    S_DN_WAIT,
    S_DN_CMP,
    S_DN_WR,
    S_ROOT_RD,
    S_ROOT_WAIT,
    S_OUT
  } state_t;

endpackage

// ===== rtl/bhpq_ram.sv =====
// generic single-write dual-read ram with registered read data
module bhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/bhpq_front.sv =====
// input front: decodes ops into a two-entry command queue
module bhpq_front #(
  parameter int KEY_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [39:0]          in_tdata,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output bhpq_pkg::cmd_t       cmd_kind,
  output logic [KEY_WIDTH-1:0] cmd_key
);

  typedef struct packed {
    bhpq_pkg::cmd_t       kind;
    logic [KEY_WIDTH-1:0] key;
  } entry_t;

  entry_t     q_r [2];
  logic [1:0] cnt_r;
  logic       rd_r, wr_r;
  entry_t     dec;
  logic       push_q, pop_q;

  always_comb begin
    case (in_tdata[1:0])
      bhpq_pkg::OP_PUSH: dec.kind = bhpq_pkg::CMD_PUSH;
      bhpq_pkg::OP_POP:  dec.kind = bhpq_pkg::CMD_POP;
      default:           dec.kind = bhpq_pkg::CMD_PEEK;
    endcase
    dec.key = in_tdata[2 +: KEY_WIDTH];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push_q    = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop_q     = cmd_valid && cmd_ready;
  assign cmd_kind  = q_r[rd_r].kind;
  assign cmd_key   = q_r[rd_r].key;

  always_ff @(posedge clk) begin
    if (push_q) begin
      q_r[wr_r] <= dec;
    end
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (push_q) wr_r <= ~wr_r;
      if (pop_q)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push_q} - {1'b0, pop_q};
    end
  end

endmodule

// ===== rtl/bhpq_back.sv =====
// heap engine: sift-up and sift-down over the key memory
module bhpq_back #(
  parameter int DEPTH     = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  min_first,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  bhpq_pkg::cmd_t        cmd_kind,
  input  logic [KEY_WIDTH-1:0]  cmd_key,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           top_key,
  output logic [1:0]            status,
  output logic [10:0]           count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  bhpq_pkg::state_t st_r, st_nxt;
  logic [CW-1:0]        cnt_r;
  logic [AW-1:0]        pos_r;
  logic [KEY_WIDTH-1:0] key_r;      // key being sifted
  logic [KEY_WIDTH-1:0] top_r;
  logic [1:0]           status_r;
  logic                 oval_r;
  logic                 cmd_is_pop_r;

  logic                 we;
  logic [AW-1:0]        waddr, ra, rb;
  logic [KEY_WIDTH-1:0] wdata, rda, rdb;

  bhpq_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(ra), .rdata_a(rda), .raddr_b(rb), .rdata_b(rdb)
  );

  function automatic logic above(input logic mf, input logic [KEY_WIDTH-1:0] a,
                                 input logic [KEY_WIDTH-1:0] b);
    return mf ? (a < b) : (a > b);
  endfunction

  // child indices, wide enough to exceed the array
  logic [CW:0] left_w, right_w;
  logic [AW-1:0] parent_w;
  logic        l_ok, r_ok, pick_r, l_better;
  assign left_w   = (CW + 1)'({pos_r, 1'b1});
  assign right_w  = left_w + 1'b1;
  assign parent_w = (pos_r - 1'b1) >> 1;
  assign l_ok     = left_w < {1'b0, cnt_r};
  assign r_ok     = right_w < {1'b0, cnt_r};
  assign l_better = l_ok && above(min_first, rda, key_r);
  assign pick_r   = r_ok && above(min_first, rdb, l_better ? rda : key_r);

  assign cmd_ready  = (st_r == bhpq_pkg::S_IDLE) && !oval_r;
  assign out_tvalid = oval_r;
  assign top_key    = 32'(top_r);
  assign status     = status_r;
  assign count      = 11'(cnt_r);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      bhpq_pkg::S_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          if (cmd_kind == bhpq_pkg::CMD_PUSH) begin
            st_nxt = (cnt_r == CW'(DEPTH)) ? bhpq_pkg::S_OUT : bhpq_pkg::S_UP_RD;
          end else if (cnt_r == '0) begin
            st_nxt = bhpq_pkg::S_OUT;
          end else begin
            st_nxt = bhpq_pkg::S_ROOT_RD;
          end
        end
      end
      bhpq_pkg::S_UP_RD:    st_nxt = (pos_r == '0) ? bhpq_pkg::S_OUT : bhpq_pkg::S_UP_WAIT;
      bhpq_pkg::S_UP_WAIT:  st_nxt = bhpq_pkg::S_UP_CMP;
      bhpq_pkg::S_UP_CMP:   st_nxt = above(min_first, key_r, rda) ?
                                     bhpq_pkg::S_UP_RD : bhpq_pkg::S_OUT;
      bhpq_pkg::S_ROOT_RD:  st_nxt = bhpq_pkg::S_ROOT_WAIT;
      // pop with keys left sifts down; otherwise result goes straight out
      bhpq_pkg::S_ROOT_WAIT: st_nxt = (cmd_is_pop_r && cnt_r > CW'(1)) ?
                                      bhpq_pkg::S_DN_RD : bhpq_pkg::S_OUT;
      bhpq_pkg::S_DN_RD:    st_nxt = bhpq_pkg::S_DN_WAIT;
      bhpq_pkg::S_DN_WAIT:  st_nxt = bhpq_pkg::S_DN_CMP;
      bhpq_pkg::S_DN_CMP:   st_nxt = (l_better || pick_r) ?
                                     bhpq_pkg::S_DN_RD : bhpq_pkg::S_OUT;
      bhpq_pkg::S_DN_WR:    st_nxt = bhpq_pkg::S_OUT;
      bhpq_pkg::S_OUT:      st_nxt = bhpq_pkg::S_IDLE;
      default:              st_nxt = bhpq_pkg::S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    we    = 1'b0;
    waddr = pos_r;
    wdata = key_r;
    ra    = parent_w;
    rb    = '0;
    unique case (st_r)
      bhpq_pkg::S_UP_RD: begin
        // place the key at its current slot; later swaps overwrite
        we = 1'b1;
      end
      bhpq_pkg::S_UP_CMP: begin
        if (above(min_first, key_r, rda)) begin
          we    = 1'b1;
          wdata = rda;
        end
      end
      bhpq_pkg::S_ROOT_RD: begin
        ra = '0;
        rb = AW'(cnt_r - 1'b1);
      end
      bhpq_pkg::S_DN_RD: begin
        we = 1'b1;
        ra = left_w[AW-1:0];
        rb = right_w[AW-1:0];
      end
      bhpq_pkg::S_DN_WAIT: begin
        // hold the child addresses so the compare sees them
        ra = left_w[AW-1:0];
        rb = right_w[AW-1:0];
      end
      bhpq_pkg::S_DN_CMP: begin
        if (l_better || pick_r) begin
          we    = 1'b1;
          wdata = pick_r ? rdb : rda;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      bhpq_pkg::S_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          key_r    <= cmd_key;
          top_r    <= '0;
          status_r <= bhpq_pkg::ST_OK;
          pos_r    <= AW'(cnt_r);
          if (cmd_kind == bhpq_pkg::CMD_PUSH) begin
            if (cnt_r == CW'(DEPTH)) status_r <= bhpq_pkg::ST_FULL;
          end else if (cnt_r == '0) begin
            status_r <= bhpq_pkg::ST_EMPTY;
          end
        end
      end
      bhpq_pkg::S_UP_CMP: begin
        if (above(min_first, key_r, rda)) pos_r <= parent_w;
      end
      bhpq_pkg::S_ROOT_WAIT: begin
        top_r <= rda;
        key_r <= rdb;
        pos_r <= '0;
      end
      bhpq_pkg::S_DN_CMP: begin
        if (pick_r)        pos_r <= right_w[AW-1:0];
        else if (l_better) pos_r <= left_w[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= bhpq_pkg::S_IDLE;
      cnt_r  <= '0;
      oval_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == bhpq_pkg::S_IDLE && cmd_valid && cmd_ready) begin
        if (cmd_kind == bhpq_pkg::CMD_PUSH && cnt_r != CW'(DEPTH)) cnt_r <= cnt_r + 1'b1;
      end
      if (st_r == bhpq_pkg::S_ROOT_WAIT && cmd_is_pop_r) cnt_r <= cnt_r - 1'b1;
      if (st_r == bhpq_pkg::S_OUT) oval_r <= 1'b1;
      else if (oval_r && out_tready) oval_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == bhpq_pkg::S_IDLE) cmd_is_pop_r <= (cmd_kind == bhpq_pkg::CMD_POP);
  end

endmodule

// ===== rtl/binary_heap_priority_queue.sv =====
// Array binary heap priority queue, min-first or max-first by cfg_wdata.
// One item is handled at a time by the heap engine. A push climbs the heap
// level by level and a pop descends it level by level; a peek and a refused
// op walk no levels. With DEPTH 1024 the worst case is a pop. The limit is
// the read, compare and write-back per level on the single key memory. A
// two-entry command queue in front lets new items be taken while the engine
// is busy.
module binary_heap_priority_queue #(
  parameter int DEPTH     = 1024,
  parameter int KEY_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // op[1:0], key[33:2], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // top_key[31:0], status[33:32], count[44:34], zero pad
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  logic                 min_first_r;
  logic                 cmd_valid, cmd_ready;
  bhpq_pkg::cmd_t       cmd_kind;
  logic [KEY_WIDTH-1:0] cmd_key;
  logic [31:0]          top_key;
  logic [1:0]           status;
  logic [10:0]          count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_first_r <= 1'b1;
    end else if (cfg_we) begin
      min_first_r <= cfg_wdata;
    end
  end

  bhpq_front #(.KEY_WIDTH(KEY_WIDTH)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .cmd_valid, .cmd_ready, .cmd_kind, .cmd_key
  );

  bhpq_back #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_back (
    .clk, .rst_n, .min_first(min_first_r),
    .cmd_valid, .cmd_ready, .cmd_kind, .cmd_key,
    .out_tvalid, .out_tready, .top_key, .status, .count
  );

  assign out_tdata = {3'b000, count, status, top_key};

endmodule

// ===== tb/tb_binary_heap_priority_queue.sv =====
// testbench of the binary heap priority queue: directed table, fill to full, then random ops
`timescale 1ns / 100ps

module tb_binary_heap_priority_queue;

  localparam int HEAP_DEPTH = 1024;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [31:0] top_key;
    logic [1:0]  status;
    logic [10:0] count;
  } heap_result_t;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] key;
    bit          has_exp;
    logic [31:0] exp_top;
    logic [1:0]  exp_status;
  } op_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // op[1:0], key[33:2], zero pad
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // top_key[31:0], status[33:32], count[44:34], zero pad
  logic        cfg_we;
  logic        cfg_wdata;

  binary_heap_priority_queue i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // shadow heap
  logic [31:0] shadow_heap [HEAP_DEPTH];
  int          shadow_fill;
  logic        shadow_min_first;

  heap_result_t pending_results[$];
  int           error_count;
  int           idle_cycles;
  int           out_seen;
  int           out_paced;
  int           out_wait;

  function automatic bit key_ranks_above(logic [31:0] a, logic [31:0] b);
    return shadow_min_first ? (a < b) : (a > b);
  endfunction

  function automatic heap_result_t apply_heap_op(logic [1:0] op, logic [31:0] key);
    heap_result_t r;
    int           pos;
    int           parent;
    int           best;
    int           lc;
    logic [31:0]  t;
    r = '0;
    if (op == bhpq_pkg::OP_PUSH) begin
      if (shadow_fill >= HEAP_DEPTH) begin
        r.status = bhpq_pkg::ST_FULL;
      end else begin
        shadow_heap[shadow_fill] = key;
        pos = shadow_fill;
        shadow_fill++;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (!key_ranks_above(shadow_heap[pos], shadow_heap[parent])) break;
          t = shadow_heap[pos];
          shadow_heap[pos] = shadow_heap[parent];
          shadow_heap[parent] = t;
          pos = parent;
        end
        r.status = bhpq_pkg::ST_OK;
      end
    end else if (shadow_fill == 0) begin
      r.status = bhpq_pkg::ST_EMPTY;
    end else begin
      r.top_key = shadow_heap[0];
      r.status = bhpq_pkg::ST_OK;
      // op three decodes by its high bit as a peek
      if (op == bhpq_pkg::OP_POP) begin
        shadow_fill--;
        if (shadow_fill > 0) begin
          shadow_heap[0] = shadow_heap[shadow_fill];
          pos = 0;
          while (pos < shadow_fill) begin
            best = pos;
            lc = 2 * pos + 1;
            if (lc < shadow_fill && key_ranks_above(shadow_heap[lc], shadow_heap[best]))
              best = lc;
            if (lc + 1 < shadow_fill &&
                key_ranks_above(shadow_heap[lc + 1], shadow_heap[best]))
              best = lc + 1;
            if (best == pos) break;
            t = shadow_heap[pos];
            shadow_heap[pos] = shadow_heap[best];
            shadow_heap[best] = t;
            pos = best;
          end
        end
      end
    end
    r.count = 11'(shadow_fill);
    return r;
  endfunction

  task automatic send_op(logic [1:0] op, logic [31:0] key, bit has_exp,
                         logic [31:0] exp_top, logic [1:0] exp_status);
    heap_result_t r;
    int           gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    r = apply_heap_op(op, key);
    if (has_exp && (r.top_key !== exp_top || r.status !== exp_status))
      $display("%0t: table row disagrees with prediction: exp %h/%0d pred %h/%0d",
               $time, exp_top, exp_status, r.top_key, r.status);
    if (has_exp && (r.top_key !== exp_top || r.status !== exp_status)) error_count++;
    pending_results.push_back(r);
    in_tdata  <= {6'b0, key, op};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_and_config(logic value);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_min_first = value;
  endtask

  // result checker
  always @(posedge clk) begin
    heap_result_t got;
    heap_result_t exp;
    if (rst_n && out_tvalid && out_tready) begin
      out_seen++;
      got = {out_tdata[31:0], out_tdata[33:32], out_tdata[44:34]};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        error_count++;
      end else begin
        exp = pending_results.pop_front();
        if (got.top_key !== exp.top_key) begin
          $display("%0t: top_key exp %h got %h", $time, exp.top_key, got.top_key);
          error_count++;
        end
        if (got.status !== exp.status) begin
          $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
          error_count++;
        end
        if (got.count !== exp.count) begin
          $display("%0t: count exp %0d got %0d", $time, exp.count, got.count);
          error_count++;
        end
      end
    end
  end

  // result side delays taking each result at random
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait = $urandom_range(0, 3);
      out_paced = 0;
    end else begin
      if (out_paced != out_seen) begin
        out_paced = out_seen;
        out_wait = $urandom_range(0, 3);
      end
      out_tready <= out_tvalid && (out_wait == 0);
      if (out_tvalid && out_wait > 0) out_wait--;
    end
  end

  // watchdog on transfers
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  op_row_t directed[$];

  function automatic op_row_t row(logic [1:0] op, logic [31:0] key, bit has_exp,
                                  logic [31:0] et, logic [1:0] es);
    op_row_t x;
    x.op = op; x.key = key; x.has_exp = has_exp; x.exp_top = et; x.exp_status = es;
    return x;
  endfunction

  initial begin
    int          n;
    logic [1:0]  op;
    logic [31:0] key;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b1;
    error_count = 0;
    shadow_fill = 0;
    shadow_min_first = 1'b1;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty heap, extremes, ties, op three
    directed.push_back(row(bhpq_pkg::OP_POP, 32'hFFFF_FFFF, 1, 32'h0, bhpq_pkg::ST_EMPTY));
    directed.push_back(row(bhpq_pkg::OP_PEEK, 32'h0, 1, 32'h0, bhpq_pkg::ST_EMPTY));
    directed.push_back(row(2'd3, 32'h0, 1, 32'h0, bhpq_pkg::ST_EMPTY));
    directed.push_back(row(bhpq_pkg::OP_PUSH, 32'hFFFF_FFFF, 1, 32'h0, bhpq_pkg::ST_OK));
    directed.push_back(row(bhpq_pkg::OP_PUSH, 32'h0, 1, 32'h0, bhpq_pkg::ST_OK));
    directed.push_back(row(bhpq_pkg::OP_PEEK, 32'h0, 1, 32'h0, bhpq_pkg::ST_OK));
    directed.push_back(row(bhpq_pkg::OP_PUSH, 32'h5, 0, 0, 0));
    directed.push_back(row(bhpq_pkg::OP_PUSH, 32'h5, 0, 0, 0));
    directed.push_back(row(bhpq_pkg::OP_PUSH, 32'h5, 0, 0, 0));
    directed.push_back(row(2'd3, 32'hA5A5_A5A5, 0, 0, 0));
    directed.push_back(row(bhpq_pkg::OP_POP, 32'h0, 1, 32'h0, bhpq_pkg::ST_OK));
    directed.push_back(row(bhpq_pkg::OP_POP, 32'h0, 0, 0, 0));
    directed.push_back(row(bhpq_pkg::OP_POP, 32'h0, 0, 0, 0));
    directed.push_back(row(bhpq_pkg::OP_POP, 32'h0, 0, 0, 0));
    directed.push_back(row(bhpq_pkg::OP_POP, 32'h0, 1, 32'hFFFF_FFFF, bhpq_pkg::ST_OK));
    directed.push_back(row(bhpq_pkg::OP_POP, 32'h0, 1, 32'h0, bhpq_pkg::ST_EMPTY));
    foreach (directed[i])
      send_op(directed[i].op, directed[i].key, directed[i].has_exp,
              directed[i].exp_top, directed[i].exp_status);

    // fill to full in max-first mode, refused push, then drain part
    drain_and_config(1'b0);
    for (int i = 0; i < HEAP_DEPTH; i++) send_op(bhpq_pkg::OP_PUSH, $urandom(), 0, 0, 0);
    send_op(bhpq_pkg::OP_PUSH, 32'h1234_5678, 1, 32'h0, bhpq_pkg::ST_FULL);
    send_op(bhpq_pkg::OP_PEEK, 32'h0, 0, 0, 0);
    for (int i = 0; i < 40; i++) send_op(bhpq_pkg::OP_POP, 32'h0, 0, 0, 0);

    // flip ordering with keys stored, random mixes
    for (int ph = 0; ph < 4; ph++) begin
      drain_and_config(ph[0]);
      for (int i = 0; i < 17; i++) begin
        n = $urandom_range(0, 9);
        op = (n < 5) ? bhpq_pkg::OP_PUSH : (n < 8) ? bhpq_pkg::OP_POP :
             2'($urandom_range(2, 3));
        case ($urandom_range(0, 3))
          0: key = $urandom_range(0, 7);
          1: key = 32'hFFFF_FFF8 | $urandom_range(0, 7);
          default: key = $urandom();
        endcase
        send_op(op, key, 0, 0, 0);
      end
    end
    drain_and_config(1'b1);

    while (pending_results.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bhpq_pkg.sv
rtl/bhpq_ram.sv
rtl/bhpq_front.sv
rtl/bhpq_back.sv
rtl/binary_heap_priority_queue.sv
tb/tb_binary_heap_priority_queue.sv
